// File: rtl/psts_pkg.sv
// Package: shared types, constants and codes for the trade statistics table
package psts_pkg;

	localparam int DEF_ENTRIES = 64;

	localparam int TIME_W  = 48;
	localparam int SYM_W   = 24;
	localparam int QTY_W   = 20;
	localparam int PRICE_W = 20;
	localparam int SLOT_W  = 6;
	localparam int SUMQ_W  = 40;
	localparam int VAL_W   = 64;
	localparam int ST_W    = 2;
	localparam int PROD_W  = QTY_W + PRICE_W;

	localparam logic [ST_W-1:0] ST_UPDATED = 2'd0;
	localparam logic [ST_W-1:0] ST_NEW     = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

	localparam logic CMD_TRADE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// one table entry as stored in the statistics memory
	typedef struct packed {
		logic [TIME_W-1:0]  last_time;
		logic [TIME_W-1:0]  gap_max;
		logic [SUMQ_W-1:0]  qty_sum;
		logic [VAL_W-1:0]   value_sum;
		logic [PRICE_W-1:0] price_max;
	} entry_t;

	// request to the divider
	typedef struct packed {
		logic              start;
		logic [VAL_W-1:0]  dividend;
		logic [SUMQ_W-1:0] divisor;
	} div_req_t;

	// divider status
	typedef struct packed {
		logic               busy;
		logic               done;
		logic [PRICE_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: rtl/psts_div.sv
// Module: radix-2 restoring divider with saturation of the quotient to the price width
module psts_div (
	input  logic                clk,
	input  logic                arst_n,
	input  psts_pkg::div_req_t  req,
	output psts_pkg::div_rsp_t  rsp
);
	import psts_pkg::*;

	localparam int CNT_W = $clog2(VAL_W + 1);

	logic [VAL_W-1:0]  quo_q;
	logic [SUMQ_W:0]   rem_q;
	logic [SUMQ_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [SUMQ_W+1:0] trial;
	logic [SUMQ_W:0]   shifted;

	// shift one dividend bit into the partial remainder
	always_comb begin
		shifted = {rem_q[SUMQ_W-1:0], quo_q[VAL_W-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VAL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[SUMQ_W+1]) begin
				rem_q <= trial[SUMQ_W:0];
				quo_q <= {quo_q[VAL_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[VAL_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = (|quo_q[VAL_W-1:PRICE_W]) ? {PRICE_W{1'b1}} : quo_q[PRICE_W-1:0];

endmodule

// File: rtl/psts_table.sv
// Module: key search and read-modify-write of the statistics memory
module psts_table #(
	parameter int ENTRIES = psts_pkg::DEF_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [psts_pkg::TIME_W-1:0]   trade_time,
	input  logic [psts_pkg::SYM_W-1:0]    symbol,
	input  logic [psts_pkg::QTY_W-1:0]    quantity,
	input  logic [psts_pkg::PRICE_W-1:0]  price,
	input  logic [psts_pkg::SLOT_W-1:0]   slot,
	output psts_pkg::div_req_t            div_req,
	input  psts_pkg::div_rsp_t            div_rsp,
	output logic                          done,
	output logic [psts_pkg::ST_W-1:0]     status,
	output logic [psts_pkg::SYM_W-1:0]    entry_symbol,
	output logic [psts_pkg::TIME_W-1:0]   max_gap,
	output logic [psts_pkg::SUMQ_W-1:0]   total_qty,
	output logic [psts_pkg::PRICE_W-1:0]  avg_price,
	output logic [psts_pkg::PRICE_W-1:0]  top_price
);
	import psts_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 2);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SEARCH = 7'b0000010,
		S_RDWAIT = 7'b0000100,
		S_MODIFY = 7'b0001000,
		S_DIV    = 7'b0010000,
		S_EMIT   = 7'b0100000,
		S_BLANK  = 7'b1000000
	} state_t;

	state_t state_q;

	// key memory and statistics memory
	logic [SYM_W-1:0] key_mem [ENTRIES];
	entry_t           stat_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   fill_q;

	logic [SYM_W-1:0] key_rd_q;
	entry_t           stat_rd_q;
	logic [IDX_W-1:0] kaddr;
	logic [IDX_W-1:0] saddr;
	logic             swe;
	entry_t           swdata;

	// captured request
	logic               cmd_q;
	logic [TIME_W-1:0]  time_q;
	logic [SYM_W-1:0]   sym_q;
	logic [QTY_W-1:0]   qty_q;
	logic [PRICE_W-1:0] price_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   scan_q;
	logic               pend_q;
	logic               isnew_q;
	logic [ST_W-1:0]    st_q;
	entry_t             res_q;
	logic [SYM_W-1:0]   rsym_q;
	logic [PRICE_W-1:0] avg_q;
	logic [PROD_W-1:0]  prod_q;

	logic               kwe;
	entry_t             upd;
	entry_t             base;
	logic [TIME_W-1:0]  gap;
	logic [SUMQ_W:0]    qsum;
	logic [VAL_W:0]     vsum;
	logic               hit;

	// key memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (kwe)
			key_mem[fill_q[IDX_W-1:0]] <= sym_q;
		key_rd_q <= key_mem[kaddr];
	end

	// statistics memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (swe)
			stat_mem[idx_q] <= swdata;
		stat_rd_q <= stat_mem[saddr];
	end

	// scan during the search, then read the chosen entry's key
	assign kaddr = (state_q == S_IDLE) ? IDX_W'(0) :
		(state_q == S_SEARCH) ? scan_q[IDX_W-1:0] : idx_q;
	assign saddr = idx_q;

	// a pending compare checks the key registered from the previous cycle's scan address
	assign hit = pend_q && valid_q[scan_q[IDX_W-1:0] - 1'b1] && (key_rd_q == sym_q);

	// entry update
	always_comb begin
		base = isnew_q ? '0 : stat_rd_q;
		upd  = base;
		gap  = time_q - base.last_time;
		if (base.last_time != '0 && time_q > base.last_time && gap > base.gap_max)
			upd.gap_max = gap;
		upd.last_time = time_q;
		if (price_q > base.price_max)
			upd.price_max = price_q;
		qsum = {1'b0, base.qty_sum} + {{(SUMQ_W+1-QTY_W){1'b0}}, qty_q};
		upd.qty_sum = qsum[SUMQ_W] ? {SUMQ_W{1'b1}} : qsum[SUMQ_W-1:0];
		vsum = {1'b0, base.value_sum} + {{(VAL_W+1-PROD_W){1'b0}}, prod_q};
		upd.value_sum = vsum[VAL_W] ? {VAL_W{1'b1}} : vsum[VAL_W-1:0];
	end

	// allocate the next free slot when the search misses and a slot is free
	assign kwe    = (state_q == S_SEARCH) && !hit
		&& (scan_q == CNT_W'(ENTRIES) + 1'b1 || !pend_q) && fill_q != CNT_W'(ENTRIES);
	assign swe    = (state_q == S_MODIFY) && (cmd_q == CMD_TRADE);
	assign swdata = upd;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			fill_q  <= '0;
			scan_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						scan_q <= CNT_W'(1);
						pend_q <= 1'b1;
						if (command == CMD_READ) begin
							if ({{(32-SLOT_W){1'b0}}, slot} >= 32'(ENTRIES))
								state_q <= S_BLANK;
							else if (!valid_q[IDX_W'(slot)])
								state_q <= S_BLANK;
							else
								state_q <= S_RDWAIT;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (hit) begin
						pend_q  <= 1'b0;
						state_q <= S_RDWAIT;
					end else if (scan_q == CNT_W'(ENTRIES) + 1'b1 || !pend_q) begin
						pend_q <= 1'b0;
						if (fill_q == CNT_W'(ENTRIES)) begin
							state_q <= S_BLANK;
						end else begin
							valid_q[fill_q[IDX_W-1:0]] <= 1'b1;
							fill_q  <= fill_q + 1'b1;
							state_q <= S_RDWAIT;
						end
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_RDWAIT: state_q <= S_MODIFY;
				S_MODIFY: state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done)
						state_q <= S_EMIT;
				end
				S_EMIT:  state_q <= S_IDLE;
				S_BLANK: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q   <= command;
					time_q  <= trade_time;
					sym_q   <= symbol;
					qty_q   <= quantity;
					price_q <= price;
					idx_q   <= IDX_W'(slot);
					isnew_q <= 1'b0;
					st_q    <= (command == CMD_READ) ? ST_EMPTY : ST_FULL;
				end
			end
			S_SEARCH: begin
				prod_q <= PROD_W'(qty_q) * PROD_W'(price_q);
				if (hit) begin
					idx_q <= scan_q[IDX_W-1:0] - 1'b1;
					st_q  <= ST_UPDATED;
				end else if (scan_q == CNT_W'(ENTRIES) + 1'b1 || !pend_q) begin
					idx_q   <= fill_q[IDX_W-1:0];
					isnew_q <= 1'b1;
					st_q    <= (fill_q == CNT_W'(ENTRIES)) ? ST_FULL : ST_NEW;
				end
			end
			S_RDWAIT: begin
				if (cmd_q == CMD_READ)
					st_q <= ST_UPDATED;
			end
			S_MODIFY: begin
				res_q  <= (cmd_q == CMD_TRADE) ? upd : stat_rd_q;
				rsym_q <= (cmd_q == CMD_TRADE) ? sym_q : key_rd_q;
			end
			S_DIV: begin
				if (div_rsp.done)
					avg_q <= (res_q.qty_sum == '0) ? '0 : div_rsp.quotient;
			end
			default: ;
		endcase
	end

	assign div_req.start    = (state_q == S_MODIFY);
	assign div_req.dividend = (cmd_q == CMD_TRADE) ? upd.value_sum : stat_rd_q.value_sum;
	assign div_req.divisor  = (cmd_q == CMD_TRADE) ? upd.qty_sum : stat_rd_q.qty_sum;

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_EMIT) || (state_q == S_BLANK);

	// result ports: blank on table full or empty slot
	always_comb begin
		status       = st_q;
		entry_symbol = '0;
		max_gap      = '0;
		total_qty    = '0;
		avg_price    = '0;
		top_price    = '0;
		if (state_q == S_EMIT) begin
			entry_symbol = rsym_q;
			max_gap      = res_q.gap_max;
			total_qty    = res_q.qty_sum;
			avg_price    = avg_q;
			top_price    = res_q.price_max;
		end
	end

endmodule

// File: rtl/per_symbol_trade_statistics.sv
// Top level: per-symbol trade statistics table with command-style interface
// A trade scans the key memory one entry per cycle, stopping early on a hit,
// then reads, updates and writes back its statistics entry and runs a 64-step
// divider for the average. A slot read skips the scan but runs the divider
// too. The scan and the divider set how long busy stays high, and no new
// transfer is taken until busy falls.
// A result appears for one cycle with done high and cannot be stalled.
// An empty slot answers on the cycle after the transfer; a trade dropped on a
// full table answers after the full scan; both carry zero fields.
module per_symbol_trade_statistics #(
	parameter int ENTRIES = psts_pkg::DEF_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [psts_pkg::TIME_W-1:0]   trade_time,
	input  logic [psts_pkg::SYM_W-1:0]    symbol,
	input  logic [psts_pkg::QTY_W-1:0]    quantity,
	input  logic [psts_pkg::PRICE_W-1:0]  price,
	input  logic [psts_pkg::SLOT_W-1:0]   slot,
	output logic                          done,
	output logic [psts_pkg::ST_W-1:0]     status,
	output logic [psts_pkg::SYM_W-1:0]    entry_symbol,
	output logic [psts_pkg::TIME_W-1:0]   max_gap,
	output logic [psts_pkg::SUMQ_W-1:0]   total_qty,
	output logic [psts_pkg::PRICE_W-1:0]  avg_price,
	output logic [psts_pkg::PRICE_W-1:0]  top_price
);
	import psts_pkg::*;

	div_req_t div_req;
	div_rsp_t div_rsp;

	psts_table #(.ENTRIES(ENTRIES)) u_table (
		.clk, .arst_n, .start, .busy, .command, .trade_time, .symbol,
		.quantity, .price, .slot, .div_req, .div_rsp, .done, .status,
		.entry_symbol, .max_gap, .total_qty, .avg_price, .top_price
	);

	psts_div u_div (
		.clk, .arst_n, .req(div_req), .rsp(div_rsp)
	);

	// no transfer is accepted while a result is being produced
	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result without active item");

	// a transfer starts work on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted item not started");

	// the divider only finishes while it was running
	assert property (@(posedge clk) disable iff (!arst_n) div_rsp.done |-> $past(div_rsp.busy))
		else $error("divider done without run");

	// blank results carry zero fields; the check looks at the total quantity
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_FULL || status == ST_EMPTY)) |-> (total_qty == '0))
		else $error("blank result carries data");

endmodule
